>>> hdl/snes_pad_reader_hid_report_defines.svh
// ----------------------------------------------------------------------------
// snes_pad_reader_hid_report_defines.svh
// Assertion macros shared by the pad reader RTL.
// ----------------------------------------------------------------------------
`ifndef SNES_PAD_READER_HID_REPORT_DEFINES_SVH
`define SNES_PAD_READER_HID_REPORT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Types and constants of the pad reader.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned FRAME_BITS = 16;

  typedef enum logic [2:0] {
    PH_LATCH = 3'd0,
    PH_HIGH  = 3'd1,
    PH_LOW   = 3'd2,
    PH_CHECK = 3'd3,
    PH_GAP   = 3'd4
  } phase_t;

  // configuration register indexes
  localparam logic [7:0] REG_LATCH_TICKS  = 8'd0;
  localparam logic [7:0] REG_HALF_PERIOD  = 8'd1;
  localparam logic [7:0] REG_POLL_GAP     = 8'd2;
  localparam logic [7:0] REG_BUTTON_ORDER = 8'd3;

  localparam logic [15:0] LATCH_TICKS_RST  = 16'd12;
  localparam logic [15:0] HALF_PERIOD_RST  = 16'd6;
  localparam logic [15:0] POLL_GAP_RST     = 16'd100;
  localparam logic [31:0] BUTTON_ORDER_RST = 32'h4387_2156;

  // direction bits in the upper frame byte
  localparam logic [7:0] DIR_RIGHT   = 8'h01;
  localparam logic [7:0] DIR_LEFT    = 8'h02;
  localparam logic [7:0] DIR_DOWN    = 8'h04;
  localparam logic [7:0] DIR_UP      = 8'h08;
  localparam logic [7:0] BUTTON_MASK = 8'hF0;

  localparam logic [7:0] AXIS_MIN    = 8'd0;
  localparam logic [7:0] AXIS_CENTER = 8'd128;
  localparam logic [7:0] AXIS_MAX    = 8'd255;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] buttons;
  } report_t;

  localparam report_t REPORT_RST = '{x: AXIS_CENTER, y: AXIS_CENTER, buttons: 8'd0};

endpackage

>>> hdl/spr_report.sv
// ----------------------------------------------------------------------------
// spr_report
// Builds axis bytes and the reordered button byte from one pad frame.
// ----------------------------------------------------------------------------
module spr_report (
  input  logic [spr_pkg::FRAME_BITS-1:0] frame,
  input  logic [31:0]                    button_order,
  output spr_pkg::report_t               report
);

  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] src;
  logic [7:0] btn;

  assign hi  = frame[15:8];
  assign lo  = frame[7:0];
  assign src = (hi & spr_pkg::BUTTON_MASK) | {4'd0, lo[7:4]};

  // pick source button n (1..8) for each report bit; other codes give zero
  always_comb begin
    logic [3:0] n;
    logic [2:0] pos;
    n   = '0;
    pos = '0;
    for (int i = 0; i < 8; i++) begin
      n   = button_order[4*i +: 4];
      pos = 3'(4'd8 - n);
      btn[i] = (n >= 4'd1 && n <= 4'd8) ? src[pos] : 1'b0;
    end
  end

  always_comb begin
    report.x = spr_pkg::AXIS_CENTER;
    report.y = spr_pkg::AXIS_CENTER;
    // left overrides right, up overrides down
    if ((hi & spr_pkg::DIR_RIGHT) != 8'd0) report.x = spr_pkg::AXIS_MAX;
    if ((hi & spr_pkg::DIR_LEFT) != 8'd0)  report.x = spr_pkg::AXIS_MIN;
    if ((hi & spr_pkg::DIR_DOWN) != 8'd0)  report.y = spr_pkg::AXIS_MAX;
    if ((hi & spr_pkg::DIR_UP) != 8'd0)    report.y = spr_pkg::AXIS_MIN;
    report.buttons = btn;
  end

endmodule

>>> hdl/snes_pad_reader_hid_report.sv
// ----------------------------------------------------------------------------
// snes_pad_reader_hid_report
// Serial pad reader: drives latch and clock, shifts in a 16-bit frame and
// emits a report when the frame changed and the host is ready.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+-------------------
//  in      | in_valid/in_ready, in_data_pin,        | one tick request
//          | in_host_ready                          |
//  out     | out_valid/out_ready, out_latch_out,    | one result per tick
//          | out_clock_out, out_report_valid,       |
//          | out_pad_x, out_pad_y, out_button_bits  |
//  cfg     | cfg_valid/cfg_ready, cfg_index,        | register write
//          | cfg_data                               |
//
// Each accepted request is one tick. The whole tick step (phase machine,
// shift, compare, report build) is combinational from the state registers
// into the output register, so one request per cycle is taken while
// out_ready is high or the output slot is empty.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous active-low reset returns to the latch phase with config at its
// defaults and the report at x=128, y=128, buttons=0. cfg_ready is always high.
//
module snes_pad_reader_hid_report (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_data_pin,
  input  logic        in_host_ready,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_latch_out,
  output logic        out_clock_out,
  output logic        out_report_valid,
  output logic [7:0]  out_pad_x,
  output logic [7:0]  out_pad_y,
  output logic [7:0]  out_button_bits,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "snes_pad_reader_hid_report_defines.svh"

  localparam int unsigned FB = spr_pkg::FRAME_BITS;

  // configuration
  logic [15:0] latch_ticks_r;
  logic [15:0] half_period_r;
  logic [15:0] poll_gap_r;
  logic [31:0] button_order_r;

  // tick state
  spr_pkg::phase_t   phase_r, phase_nxt;
  logic [15:0]       tick_r, tick_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [FB-1:0]     shift_r, shift_nxt;
  logic [FB-1:0]     reported_r, reported_nxt;
  spr_pkg::report_t  rep_r, rep_nxt;

  // output register
  logic              out_valid_r;
  logic              latch_r, latch_nxt;
  logic              clock_r, clock_nxt;
  logic              rvalid_r, rvalid_nxt;
  spr_pkg::report_t  out_rep_r;

  logic              in_acc;
  logic [16:0]       tick_inc;
  logic [15:0]       half_min;
  logic [15:0]       latch_min;
  logic              frame_new;
  spr_pkg::report_t  frame_rep;

  assign cfg_ready = 1'b1;
  // take a request whenever the output slot is free or drains this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  // zero latch or half period counts as one tick
  assign half_min  = (half_period_r == 16'd0) ? 16'd1 : half_period_r;
  assign latch_min = (latch_ticks_r == 16'd0) ? 16'd1 : latch_ticks_r;
  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign frame_new = shift_r != reported_r;

  spr_report u_report (
    .frame        (shift_r),
    .button_order (button_order_r),
    .report       (frame_rep)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_ticks_r  <= spr_pkg::LATCH_TICKS_RST;
      half_period_r  <= spr_pkg::HALF_PERIOD_RST;
      poll_gap_r     <= spr_pkg::POLL_GAP_RST;
      button_order_r <= spr_pkg::BUTTON_ORDER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        spr_pkg::REG_LATCH_TICKS:  latch_ticks_r  <= cfg_data[15:0];
        spr_pkg::REG_HALF_PERIOD:  half_period_r  <= cfg_data[15:0];
        spr_pkg::REG_POLL_GAP:     poll_gap_r     <= cfg_data[15:0];
        spr_pkg::REG_BUTTON_ORDER: button_order_r <= cfg_data;
        default: ; // drop writes outside the register list
      endcase
    end
  end

  // one tick of the phase machine
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_inc[15:0];
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    reported_nxt = reported_r;
    rep_nxt      = rep_r;
    latch_nxt    = 1'b0;
    clock_nxt    = 1'b1;
    rvalid_nxt   = 1'b0;
    case (phase_r)
      spr_pkg::PH_HIGH: begin
        if (tick_inc >= {1'b0, half_min}) begin
          tick_nxt  = '0;
          phase_nxt = spr_pkg::PH_LOW;
        end
      end
      spr_pkg::PH_LOW: begin
        clock_nxt = 1'b0;
        // sample on the falling clock, inverted so pressed reads as one
        if (tick_r == 16'd0) shift_nxt = {shift_r[FB-2:0], ~in_data_pin};
        if (tick_inc >= {1'b0, half_min}) begin
          tick_nxt  = '0;
          bit_nxt   = bit_r + 5'd1;
          phase_nxt = (bit_nxt >= 5'(FB)) ? spr_pkg::PH_CHECK : spr_pkg::PH_HIGH;
        end
      end
      spr_pkg::PH_CHECK: begin
        if (in_host_ready && frame_new) begin
          reported_nxt = shift_r;
          rep_nxt      = frame_rep;
          rvalid_nxt   = 1'b1;
        end
        tick_nxt  = '0;
        phase_nxt = (poll_gap_r == 16'd0) ? spr_pkg::PH_LATCH : spr_pkg::PH_GAP;
      end
      spr_pkg::PH_GAP: begin
        if (tick_inc >= {1'b0, poll_gap_r}) begin
          tick_nxt  = '0;
          phase_nxt = spr_pkg::PH_LATCH;
        end
      end
      default: begin
        // latch phase, and any stray code
        latch_nxt = 1'b1;
        if (tick_inc >= {1'b0, latch_min}) begin
          tick_nxt  = '0;
          bit_nxt   = '0;
          phase_nxt = spr_pkg::PH_HIGH;
        end else begin
          phase_nxt = spr_pkg::PH_LATCH;
        end
      end
    endcase
  end

  // advance state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= spr_pkg::PH_LATCH;
      tick_r     <= '0;
      bit_r      <= '0;
      shift_r    <= '0;
      reported_r <= '0;
      rep_r      <= spr_pkg::REPORT_RST;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      reported_r <= reported_nxt;
      rep_r      <= rep_nxt;
    end
  end

  // output slot: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      latch_r   <= latch_nxt;
      clock_r   <= clock_nxt;
      rvalid_r  <= rvalid_nxt;
      out_rep_r <= rep_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_latch_out    = latch_r;
  assign out_clock_out    = clock_r;
  assign out_report_valid = rvalid_r;
  assign out_pad_x        = out_rep_r.x;
  assign out_pad_y        = out_rep_r.y;
  assign out_button_bits  = out_rep_r.buttons;

  // a report can only come from the check tick
  `SPR_ASSERT_NEXT(a_report_from_check, clk, rst_n, in_acc && phase_r != spr_pkg::PH_CHECK, !rvalid_r, "report outside check tick")

  // latch high never coincides with clock low
  `SPR_ASSERT_NOW(a_latch_clock, clk, rst_n, out_valid_r, !(latch_r && !clock_r), "latch high while clock low")

  // bit counter never runs past the frame length
  `SPR_ASSERT_NOW(a_bit_range, clk, rst_n, 1'b1, bit_r <= 5'(FB), "bit counter past frame length")

  // a report records the frame it was built from
  `SPR_ASSERT_NEXT(a_reported_frame, clk, rst_n, in_acc && phase_r == spr_pkg::PH_CHECK && in_host_ready && frame_new, reported_r == $past(shift_r) && rvalid_r, "reported frame not updated")

endmodule

>>> dv/snes_pad_reader_hid_report_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snes_pad_reader_hid_report_tb
// Self-checking bench for the pad reader. Every tick request is mirrored
// into a cycle-true model of the latch/clock sequencer and report encoder;
// each tick result is checked field by field against that model, or against
// hand-entered values for the directed frames. The pad is emulated by
// driving the data pin from a chosen button frame in step with the bit count.
// ----------------------------------------------------------------------------
module snes_pad_reader_hid_report_tb;

  // write to an index the block does not decode; nothing may change
  localparam logic [7:0] REG_UNUSED = 8'hFF;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // line levels and report fields for one tick
  typedef struct packed {
    logic       latch;
    logic       sclk;
    logic       rv;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] btn;
  } pad_tick_t;

  // one directed frame: timing, button order, pad frame, host state and,
  // where chk is set, the report that the check tick must carry
  typedef struct packed {
    logic [15:0] lat;
    logic [15:0] half;
    logic [15:0] gap;
    logic [31:0] order;
    logic [15:0] frame;
    logic        host;
    logic        chk;
    logic        rv;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  btn;
  } pad_case_t;

  localparam pad_case_t PAD_CASES [15] = '{
    // reset timing, idle pad: frame equals the reset frame, so no report
    '{spr_pkg::LATCH_TICKS_RST, spr_pkg::HALF_PERIOD_RST, spr_pkg::POLL_GAP_RST,
      spr_pkg::BUTTON_ORDER_RST,
      16'h0000, 1'b1, 1'b1, 1'b0, 8'd128, 8'd128, 8'h00},
    // zero latch/half act as one tick, zero gap skips the gap; all pressed: left and up win
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'hFFF0, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'hFF},
    // same frame again: no report, fields hold
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'hFFF0, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 8'hFF},
    // host busy: new frame is not reported
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'h0100, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'hFF},
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'h0100, 1'b1, 1'b1, 1'b1, 8'd255, 8'd128, 8'h00},
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'h0400, 1'b1, 1'b1, 1'b1, 8'd128, 8'd255, 8'h00},
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'h0A00, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'h00},
    // nibbles outside 1..8 give zero bits
    '{16'd0, 16'd0, 16'd0, 32'h0000_0000,
      16'hF0F0, 1'b1, 1'b1, 1'b1, 8'd128, 8'd128, 8'h00},
    '{16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF,
      16'h00F0, 1'b1, 1'b1, 1'b1, 8'd128, 8'd128, 8'h00},
    // straight order: B lands on bit 0, R on bit 7
    '{16'd0, 16'd0, 16'd0, 32'h8765_4321,
      16'h8000, 1'b1, 1'b1, 1'b1, 8'd128, 8'd128, 8'h01},
    '{16'd0, 16'd0, 16'd0, 32'h8765_4321,
      16'h0010, 1'b1, 1'b1, 1'b1, 8'd128, 8'd128, 8'h80},
    '{16'd0, 16'd0, 16'd0, 32'h9999_9999,
      16'hFFF0, 1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'h00},
    '{16'd0, 16'd0, 16'd0, spr_pkg::BUTTON_ORDER_RST,
      16'h0000, 1'b1, 1'b1, 1'b1, 8'd128, 8'd128, 8'h00},
    // checked against the model only
    '{16'd3, 16'd2, 16'd5, 32'h1234_5678,
      16'h5A5F, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 8'h00},
    '{16'd1, 16'd1, 16'd1, 32'h8163_2745,
      16'hA5A3, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_data_pin;
  logic        in_host_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_latch_out;
  logic        out_clock_out;
  logic        out_report_valid;
  logic [7:0]  out_pad_x;
  logic [7:0]  out_pad_y;
  logic [7:0]  out_button_bits;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  // model of the reader: configuration
  logic [15:0] set_latch;
  logic [15:0] set_half;
  logic [15:0] set_gap;
  logic [31:0] set_order;
  // model of the reader: sequencer and report state
  spr_pkg::phase_t  rd_phase;
  logic [15:0]      rd_ticks;
  logic [4:0]       rd_bits;
  logic [15:0]      rd_shift;
  logic [15:0]      rd_last_frame;
  spr_pkg::report_t rd_report;

  pad_tick_t   pending_ticks [$];
  int          err_cnt = 0;

  // sender pacing and the emulated pad
  bit          idle_on;
  int          burst_left;
  logic [15:0] pad_frame;

  // receiver stall control
  logic [31:0] rx_cyc = '0;
  int unsigned hold_left = 0;
  bit          hold_off_go = 1'b0;

  always #1 clk = ~clk;

  snes_pad_reader_hid_report dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_pin      (in_data_pin),
    .in_host_ready    (in_host_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_latch_out    (out_latch_out),
    .out_clock_out    (out_clock_out),
    .out_report_valid (out_report_valid),
    .out_pad_x        (out_pad_x),
    .out_pad_y        (out_pad_y),
    .out_button_bits  (out_button_bits),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // A zero latch or half period still lasts one tick.
  function automatic int unsigned floor_one(input logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  // Build axes and the reordered button byte from a finished frame.
  function automatic spr_pkg::report_t encode_report(input logic [15:0] frame);
    logic [7:0]       hi;
    logic [7:0]       src;
    logic [3:0]       n;
    spr_pkg::report_t rp;
    hi = frame[15:8];
    rp.x = spr_pkg::AXIS_CENTER;
    rp.y = spr_pkg::AXIS_CENTER;
    rp.buttons = 8'd0;
    // right/down first, so left and up override on a conflict
    if ((hi & spr_pkg::DIR_RIGHT) != 0) rp.x = spr_pkg::AXIS_MAX;
    if ((hi & spr_pkg::DIR_LEFT) != 0) rp.x = spr_pkg::AXIS_MIN;
    if ((hi & spr_pkg::DIR_DOWN) != 0) rp.y = spr_pkg::AXIS_MAX;
    if ((hi & spr_pkg::DIR_UP) != 0) rp.y = spr_pkg::AXIS_MIN;
    // source byte: B Y Select Start A X L R, button n sits at bit 8-n
    src = (hi & spr_pkg::BUTTON_MASK) | {4'h0, frame[7:4]};
    for (int i = 0; i < 8; i++) begin
      n = set_order[4*i +: 4];
      if (n >= 4'd1 && n <= 4'd8) rp.buttons[i] = src[8-n];
    end
    return rp;
  endfunction

  // Advance the model by one tick and return what the block must show.
  function automatic pad_tick_t reader_step(input logic pin, input logic rdy);
    pad_tick_t   r;
    int unsigned nxt;
    r = '0;
    r.sclk = 1'b1;
    nxt = int'(rd_ticks) + 1;
    case (rd_phase)
      spr_pkg::PH_HIGH: begin
        if (nxt >= floor_one(set_half)) begin
          nxt = 0;
          rd_phase = spr_pkg::PH_LOW;
        end
      end
      spr_pkg::PH_LOW: begin
        r.sclk = 1'b0;
        // sample on the falling tick only, inverted: low pin = pressed
        if (rd_ticks == 16'd0) rd_shift = {rd_shift[14:0], ~pin};
        if (nxt >= floor_one(set_half)) begin
          nxt = 0;
          rd_bits = rd_bits + 5'd1;
          rd_phase = (rd_bits >= spr_pkg::FRAME_BITS) ? spr_pkg::PH_CHECK
                                                      : spr_pkg::PH_HIGH;
        end
      end
      spr_pkg::PH_CHECK: begin
        if (rdy && rd_shift != rd_last_frame) begin
          rd_last_frame = rd_shift;
          rd_report = encode_report(rd_shift);
          r.rv = 1'b1;
        end
        nxt = 0;
        rd_phase = (set_gap == 16'd0) ? spr_pkg::PH_LATCH : spr_pkg::PH_GAP;
      end
      spr_pkg::PH_GAP: begin
        if (nxt >= set_gap) begin
          nxt = 0;
          rd_phase = spr_pkg::PH_LATCH;
        end
      end
      default: begin
        r.latch = 1'b1;
        if (nxt >= floor_one(set_latch)) begin
          nxt = 0;
          rd_bits = 5'd0;
          rd_phase = spr_pkg::PH_HIGH;
        end
      end
    endcase
    rd_ticks = 16'(nxt);
    r.x = rd_report.x;
    r.y = rd_report.y;
    r.btn = rd_report.buttons;
    return r;
  endfunction

  // Offer one tick request and hold it until taken, then queue its result.
  // On the check tick of a directed frame, the hand-entered report replaces
  // the model's.
  task automatic offer_tick(input logic pin, input logic rdy, input bit chk,
                            input pad_tick_t forced, output bit was_check);
    pad_tick_t res;
    in_valid <= 1'b1;
    in_data_pin <= pin;
    in_host_ready <= rdy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    was_check = (rd_phase == spr_pkg::PH_CHECK);
    res = reader_step(pin, rdy);
    if (was_check && chk) begin
      res.rv = forced.rv;
      res.x = forced.x;
      res.y = forced.y;
      res.btn = forced.btn;
    end
    pending_ticks.push_back(res);
  endtask

  // Burst pacing: after each burst, drop valid for a random pause while idle_on is set.
  task automatic sender_pause();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (idle_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Stop sending and wait for every queued result, plus the output stage.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Drain, then write all four registers back to back (and optionally an
  // undecoded index), mirroring each write into the model.
  task automatic load_timing(input logic [31:0] lat, input logic [31:0] half,
                             input logic [31:0] gap, input logic [31:0] order,
                             input bit poke_unused);
    logic [7:0]  idx [5];
    logic [31:0] val [5];
    int          cnt;
    idx = '{spr_pkg::REG_LATCH_TICKS, spr_pkg::REG_HALF_PERIOD,
            spr_pkg::REG_POLL_GAP, spr_pkg::REG_BUTTON_ORDER, REG_UNUSED};
    val = '{lat, half, gap, order, $urandom};
    cnt = poke_unused ? 5 : 4;
    wait_drained();
    for (int k = 0; k < cnt; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        spr_pkg::REG_LATCH_TICKS:  set_latch = val[k][15:0];
        spr_pkg::REG_HALF_PERIOD:  set_half = val[k][15:0];
        spr_pkg::REG_POLL_GAP:     set_gap = val[k][15:0];
        spr_pkg::REG_BUTTON_ORDER: set_order = val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Run n ticks. In pad mode the pin follows pad_frame at the current bit;
  // in noisy mode the pin and host state are random every tick.
  task automatic run_ticks(input int n, input bit noisy);
    logic pin;
    logic rdy;
    bit   was_check;
    for (int t = 0; t < n; t++) begin
      if (noisy || rd_phase != spr_pkg::PH_LOW) pin = 1'($urandom_range(0, 1));
      else pin = ~pad_frame[~rd_bits[3:0]];
      rdy = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) != 0);
      offer_tick(pin, rdy, 1'b0, '0, was_check);
      // change the pressed buttons now and then, between frames
      if (was_check && $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 2))
          0: pad_frame = 16'($urandom);
          1: pad_frame = 16'(1 << $urandom_range(0, 15));
          default: pad_frame = pad_frame ^ 16'(1 << $urandom_range(4, 15));
        endcase
      end
      sender_pause();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: cycle through stall patterns chosen by rx_cyc[8:7]; on request,
  // hold off for a long stretch so the block fills and stalls its input.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_go) begin
      hold_off_go = 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case (rx_cyc[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_cyc[2:0] < 3'd5);
      endcase
    end
  end

  // Compare each accepted result with the oldest pending tick.
  always @(posedge clk) begin : check_out
    pad_tick_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing pending, expected none, got %h",
                 $time, {out_latch_out, out_clock_out, out_report_valid,
                         out_pad_x, out_pad_y, out_button_bits});
      end else begin
        want = pending_ticks.pop_front();
        check_field("latch_out", 8'(want.latch), 8'(out_latch_out));
        check_field("clock_out", 8'(want.sclk), 8'(out_clock_out));
        check_field("report_valid", 8'(want.rv), 8'(out_report_valid));
        check_field("pad_x", want.x, out_pad_x);
        check_field("pad_y", want.y, out_pad_y);
        check_field("button_bits", want.btn, out_button_bits);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("snes_pad_reader_hid_report_tb: done, errors");
    $finish;
  end

  initial begin
    pad_case_t   row;
    pad_tick_t   forced;
    logic [31:0] order_pick;
    bit          was_check;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_pin <= 1'b1;
    in_host_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= spr_pkg::REG_LATCH_TICKS;
    cfg_data <= '0;

    // model starts from the reset state
    set_latch = spr_pkg::LATCH_TICKS_RST;
    set_half = spr_pkg::HALF_PERIOD_RST;
    set_gap = spr_pkg::POLL_GAP_RST;
    set_order = spr_pkg::BUTTON_ORDER_RST;
    rd_phase = spr_pkg::PH_LATCH;
    rd_ticks = '0;
    rd_bits = '0;
    rd_shift = '0;
    rd_last_frame = '0;
    rd_report = spr_pkg::REPORT_RST;
    idle_on = 1'b1;
    burst_left = 0;
    pad_frame = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: play each pad frame tick by tick up to and including
    // its check tick. Rewrite the timing only where the row changes it, so
    // the first row runs on the reset values.
    foreach (PAD_CASES[r]) begin
      row = PAD_CASES[r];
      if ({row.lat, row.half, row.gap, row.order} !=
          {set_latch, set_half, set_gap, set_order})
        load_timing({16'h0, row.lat}, {16'h0, row.half}, {16'h0, row.gap},
                    row.order, 1'b0);
      forced = '{1'b0, 1'b1, row.rv, row.x, row.y, row.btn};
      do begin
        offer_tick(~row.frame[~rd_bits[3:0]], row.host, row.chk, forced, was_check);
        sender_pause();
      end while (!was_check);
    end

    // Random phases on short timing so that frames complete often. Garbage
    // in the upper half of the 32-bit register writes must be dropped. Every
    // timing change drains the block first, which also pauses the sender
    // until all results are in.
    for (int p = 0; p < 8; p++) begin
      idle_on = (p % 3 != 2);
      case ($urandom_range(0, 2))
        0: order_pick = spr_pkg::BUTTON_ORDER_RST;
        1: order_pick = 32'h8765_4321;
        default: order_pick = $urandom;
      endcase
      load_timing({16'($urandom), 16'($urandom_range(0, 3))},
                  {16'($urandom), 16'($urandom_range(0, 2))},
                  {16'($urandom), 16'($urandom_range(0, 6))},
                  order_pick, p == 5);
      // long receiver hold-off while requests keep coming
      if (p == 4) hold_off_go = 1'b1;
      run_ticks(45, p % 4 == 3);
    end

    // Widest latch and gap: a stretch of the long phase.
    idle_on = 1'b0;
    load_timing(32'h0000_FFFF, 32'h1, 32'h0000_FFFF, $urandom, 1'b0);
    run_ticks(30, 1'b0);

    // Widest half period: only the first slow clock phases are seen.
    idle_on = 1'b1;
    load_timing(32'h1, 32'h0000_FFFF, 32'h0, spr_pkg::BUTTON_ORDER_RST, 1'b0);
    run_ticks(30, 1'b0);

    load_timing(32'h0, 32'h0, 32'h0, $urandom, 1'b0);
    run_ticks(40, 1'b1);

    // wait out the last results and the output register
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("snes_pad_reader_hid_report_tb: done, clean");
    end else begin
      $display("snes_pad_reader_hid_report_tb: done, errors");
    end
    $finish;
  end

endmodule
